// ----- hw/rtl/bsdq_pkg.sv -----
// Shared types and codes for the bounded sequence deque.
// Used by bsdq_cell and bounded_sequence_deque_with_insert; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsdq_pkg;

    // Fixed field widths of the request and response beats
    localparam int REQ_W  = 3;
    localparam int DIN_W  = 32;
    localparam int POS_W  = 5;
    localparam int DOUT_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 6;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ_IDX   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_INSERT_AFT = 3'd5;

    // Response status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADIDX = 2'd3;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_INSERT     = 2'd1,  // load at base, cells above take left neighbor
        CELL_SHIFT_DOWN = 2'd2   // every cell takes right neighbor
    } t_cell_op;

endpackage

`default_nettype wire

// ----- hw/rtl/bsdq_cell.sv -----
// One storage cell of the deque chain: holds one entry and moves it to or
// from its neighbors. Depends on bsdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsdq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 5,
    parameter int INDEX      = 0
) (
    input  wire                      i_clk,
    input  wire  bsdq_pkg::t_cell_op i_op,
    input  wire  [IDX_W-1:0]         i_base,
    input  wire  [DATA_WIDTH-1:0]    i_val,
    input  wire  [DATA_WIDTH-1:0]    i_left,
    input  wire  [DATA_WIDTH-1:0]    i_right,
    output logic [DATA_WIDTH-1:0]    o_q
);
    import bsdq_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_q;

    // Entry register; payload only, no reset
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            CELL_INSERT: begin
                if (MY_IDX == i_base) begin
                    r_q <= i_val;
                end else if (MY_IDX > i_base) begin
                    r_q <= i_left;
                end
            end
            CELL_SHIFT_DOWN: begin
                r_q <= i_right;
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bounded_sequence_deque_with_insert.sv -----
// Bounded deque with indexed read and insert-after, built as a chain of cells.
// Depends on bsdq_pkg and bsdq_cell.
//
// Usage:
//   Request channel: i_in_valid / o_in_stall with i_req_type, i_data_in,
//   i_position. Response channel: o_out_valid / i_out_stall with o_data_out,
//   o_status, o_occupancy. Every request beat yields exactly one response beat.
//   The response is registered; it appears in the cycle after acceptance.
//   Throughput: one request per cycle while o_in_stall is low. Every cell
//   updates in parallel from the request's broadcast operation, so pushes,
//   pops and inserts at any index all finish in the accept cycle; indexed
//   reads go through one CAPACITY-way selector on the cell outputs.
//   A single output register sits between the two sides; a new request is
//   taken while a response waits if the receiver takes it in the same cycle.
//   When the receiver stalls with a response held, o_in_stall rises and the
//   held response stays unchanged.
//   Reset (i_rst_n low, synchronous) empties the sequence and drops any held
//   response; entry contents are not cleared and are never read unwritten.
`timescale 1ns / 1ps
`default_nettype none

module bounded_sequence_deque_with_insert #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // request channel
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [bsdq_pkg::REQ_W-1:0]     i_req_type,
    input  wire  signed [bsdq_pkg::DIN_W-1:0] i_data_in,
    input  wire  [bsdq_pkg::POS_W-1:0]     i_position,
    // response channel
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic signed [bsdq_pkg::DOUT_W-1:0] o_data_out,
    output logic [bsdq_pkg::STAT_W-1:0]    o_status,
    output logic [bsdq_pkg::OCC_W-1:0]     o_occupancy
);
    import bsdq_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // control state
    logic             r_out_valid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // response payload
    logic signed [DOUT_W-1:0] r_data_out;
    logic [STAT_W-1:0]        r_status;
    logic [OCC_W-1:0]         r_occupancy;
    logic signed [DOUT_W-1:0] n_data_out;
    logic [STAT_W-1:0]        n_status;

    logic                  w_accept;
    t_cell_op              w_op;
    t_cell_op              w_cell_op;
    logic [IDX_W-1:0]      w_base;
    logic [IDX_W-1:0]      w_rd_addr;
    logic signed [DATA_WIDTH-1:0] w_val;
    logic signed [DATA_WIDTH-1:0] w_rd_q;
    logic signed [DOUT_W-1:0]     w_rd_ext;
    logic [DATA_WIDTH-1:0] w_q [CAPACITY];
    logic [CMP_W-1:0]      w_pos_ext;
    logic [CMP_W-1:0]      w_cnt_ext;
    logic [CMP_W-1:0]      w_at;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_pos_ok;

    // handshake
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // stored value: low DATA_WIDTH bits, sign extended where the cell is wider
    generate
        if (DATA_WIDTH <= DIN_W) begin : g_val_narrow
            assign w_val = i_data_in[DATA_WIDTH-1:0];
        end else begin : g_val_wide
            assign w_val = DATA_WIDTH'(i_data_in);
        end
    endgenerate

    // read selector and width adjust to the 32-bit output
    assign w_rd_q = w_q[w_rd_addr];
    generate
        if (DATA_WIDTH >= DOUT_W) begin : g_rd_wide
            assign w_rd_ext = w_rd_q[DOUT_W-1:0];
        end else begin : g_rd_narrow
            assign w_rd_ext = DOUT_W'(w_rd_q);
        end
    endgenerate

    // status conditions
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_pos_ext = CMP_W'(i_position);
    assign w_cnt_ext = CMP_W'(r_count);
    assign w_pos_ok  = (w_pos_ext < w_cnt_ext);
    assign w_at      = w_pos_ext + CMP_W'(1);
    assign w_rd_addr = (i_req_type == REQ_POP_BACK) ? IDX_W'(r_count - CNT_W'(1))
                                                    : IDX_W'(i_position);

    // request decode
    always_comb begin
        n_status   = ST_OK;
        n_data_out = '0;
        n_count    = r_count;
        w_op       = CELL_HOLD;
        w_base     = '0;
        unique case (i_req_type)
            REQ_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_op    = CELL_INSERT;
                    w_base  = IDX_W'(r_count);
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_data_out = w_rd_ext;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            REQ_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_op    = CELL_INSERT;
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_op    = CELL_SHIFT_DOWN;
                    n_count = r_count - CNT_W'(1);
                    if (DATA_WIDTH >= DOUT_W) begin
                        n_data_out = DOUT_W'(w_q[0]);
                    end else begin
                        n_data_out = DOUT_W'($signed(w_q[0]));
                    end
                end
            end
            REQ_READ_IDX: begin
                if (!w_pos_ok) begin
                    n_status = ST_BADIDX;
                end else begin
                    n_data_out = w_rd_ext;
                end
            end
            REQ_INSERT_AFT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else if (!w_pos_ok) begin
                    n_status = ST_BADIDX;
                end else begin
                    w_op    = CELL_INSERT;
                    w_base  = IDX_W'(w_at);
                    n_count = r_count + CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // cells change only on an accepted beat
    assign w_cell_op = w_accept ? w_op : CELL_HOLD;

    // chain of cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            logic [DATA_WIDTH-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_q[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_q[gi+1];
            end
            bsdq_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .IDX_W      (IDX_W),
                .INDEX      (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_op    (w_cell_op),
                .i_base  (w_base),
                .i_val   (w_val),
                .i_left  (w_left),
                .i_right (w_right),
                .o_q     (w_q[gi])
            );
        end
    endgenerate

    // count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // response payload register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data_out  <= n_data_out;
            r_status    <= n_status;
            r_occupancy <= OCC_W'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_status    = r_status;
    assign o_occupancy = r_occupancy;

endmodule

`default_nettype wire
